// ===== design/ogi_pkg.sv =====
// Shared types, constants and a helper function for the occupancy grid inflation block.
package ogi_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_RADIUS = 15;

  localparam int COORD_W = 8;
  localparam int DELTA_W = 6;
  localparam int RAD_W   = 4;
  localparam int THR_W   = 7;
  localparam int DIM_W   = 7;
  localparam int XY_W    = 6;
  localparam int VAL_W   = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [THR_W-1:0] RST_THRESHOLD = 7'd50;
  localparam logic [RAD_W-1:0] RST_RADIUS    = 4'd7;
  localparam logic [DIM_W-1:0] RST_WIDTH     = 7'd64;
  localparam logic [DIM_W-1:0] RST_HEIGHT    = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic signed [VAL_W-1:0] INF_BLOCKED = 8'sd100;
  localparam logic signed [VAL_W-1:0] INF_UNKNOWN = -8'sd1;
  localparam logic signed [VAL_W-1:0] INF_FREE    = 8'sd0;

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_RADIUS,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {
    RES_UNKNOWN,
    RES_BLOCKED,
    RES_FREE
  } res_kind_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [RAD_W-1:0] radius;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic      write;
    logic      capture;
    logic      rd_center;
    logic      scan_init;
    logic      scan_step;
    logic      load_out;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic in_oob;
    logic center_unknown;
    logic center_obst;
    logic hit;
    logic last;
    logic out_busy;
  } status_t;

  function automatic logic is_obst(logic [VAL_W-1:0] v, logic [THR_W-1:0] thr);
    return !v[VAL_W-1] && (v[VAL_W-2:0] >= thr);
  endfunction

endpackage

// ===== design/ogi_ctrl.sv =====
// Controller state machine that sequences grid writes, centre checks and the disk scan.
module ogi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             op,
  output logic             in_ready,
  input  ogi_pkg::status_t status,
  output ogi_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t             state;
  ogi_pkg::res_kind_t kind;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.kind      = kind;
    unique case (state)
      ST_IDLE: begin
        cmd.write   = in_valid && (op == ogi_pkg::OP_WRITE);
        cmd.capture = in_valid && (op == ogi_pkg::OP_READ);
      end
      ST_CENTER: cmd.rd_center = 1'b1;
      ST_CHECK:  cmd.scan_init = !status.center_unknown && !status.center_obst;
      ST_SCAN:   cmd.scan_step = !status.hit;
      ST_DRAIN:  cmd.scan_step = 1'b0;
      ST_FINISH: cmd.load_out  = !status.out_busy;
      default:   cmd.write     = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= ogi_pkg::RES_UNKNOWN;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (op == ogi_pkg::OP_READ)) begin
            if (status.in_oob) begin
              kind  <= ogi_pkg::RES_UNKNOWN;
              state <= ST_FINISH;
            end else begin
              state <= ST_CENTER;
            end
          end
        end
        ST_CENTER: state <= ST_CHECK;
        ST_CHECK: begin
          priority if (status.center_unknown) begin
            kind  <= ogi_pkg::RES_UNKNOWN;
            state <= ST_FINISH;
          end else if (status.center_obst) begin
            kind  <= ogi_pkg::RES_BLOCKED;
            state <= ST_FINISH;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (status.hit) begin
            kind  <= ogi_pkg::RES_BLOCKED;
            state <= ST_FINISH;
          end else if (status.last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          kind  <= status.hit ? ogi_pkg::RES_BLOCKED : ogi_pkg::RES_FREE;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!status.out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_oob_read_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && op == ogi_pkg::OP_READ && status.in_oob)
    |=> (state == ST_FINISH && kind == ogi_pkg::RES_UNKNOWN))
    else $error("out-of-bounds read did not go straight to the result");

  a_hit_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && status.hit) |=> (state == ST_FINISH && kind == ogi_pkg::RES_BLOCKED))
    else $error("obstacle found in the scan did not give a blocked result");

  a_finish_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !status.out_busy) |-> cmd.load_out)
    else $error("result not loaded although the output register was free");

  a_no_scan_outside: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step || cmd.scan_init) |-> (state == ST_SCAN || state == ST_CHECK))
    else $error("scan command issued outside the scan");

endmodule

// ===== design/ogi_datapath.sv =====
// Datapath: raw grid memory, disk scan counters, obstacle test and output register.
module ogi_datapath #(
  parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ogi_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = ogi_pkg::DEF_MAX_RADIUS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ogi_pkg::cfg_t                     cfg,
  input  ogi_pkg::cmd_t                     cmd,
  output ogi_pkg::status_t                  status,
  input  logic [ogi_pkg::XY_W-1:0]          cell_x,
  input  logic [ogi_pkg::XY_W-1:0]          cell_y,
  input  logic signed [ogi_pkg::VAL_W-1:0]  raw_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ogi_pkg::XY_W-1:0]          result_x,
  output logic [ogi_pkg::XY_W-1:0]          result_y,
  output logic signed [ogi_pkg::VAL_W-1:0]  inflated_value,
  output logic                              free_for_planning,
  output logic                              out_of_bounds
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = ogi_pkg::COORD_W;
  localparam int DW     = ogi_pkg::DELTA_W;
  localparam int RW     = ogi_pkg::RAD_W;
  localparam int NW     = ogi_pkg::DIM_W;

  logic [ogi_pkg::VAL_W-1:0] mem [DEPTH];

  logic [NW-1:0]             w_eff;
  logic [NW-1:0]             h_eff;
  logic [RW-1:0]             r_eff;
  logic signed [DW-1:0]      r_s;
  logic                      in_oob;
  logic [ADDR_W-1:0]         in_addr;
  logic [ADDR_W-1:0]         ctr_addr;
  logic [ADDR_W-1:0]         nbr_addr;
  logic [ADDR_W-1:0]         rd_addr;

  logic [ogi_pkg::XY_W-1:0]  req_x;
  logic [ogi_pkg::XY_W-1:0]  req_y;
  logic                      req_oob;
  logic signed [DW-1:0]      dx;
  logic signed [DW-1:0]      dy;
  logic signed [CW-1:0]      nx;
  logic signed [CW-1:0]      ny;
  logic                      nbr_ok;
  logic [RW-1:0]             dx_mag;
  logic [RW-1:0]             dy_mag;
  logic [2*RW:0]             d_sq;
  logic [2*RW-1:0]           r_sq;
  logic [ogi_pkg::VAL_W-1:0] rd_data;
  logic                      rd_live;
  logic                      out_valid_next;

  assign w_eff = ({4'b0, cfg.width} > 11'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : cfg.width;
  assign h_eff = ({4'b0, cfg.height} > 11'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) : cfg.height;
  assign r_eff = ({3'b0, cfg.radius} > 7'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : cfg.radius;
  assign r_s   = $signed({{(DW-RW){1'b0}}, r_eff});

  assign in_oob  = ({1'b0, cell_x} >= w_eff) || ({1'b0, cell_y} >= h_eff);
  assign in_addr = ADDR_W'(cell_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cell_x);
  assign ctr_addr = ADDR_W'(req_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_x);

  assign nx = $signed({{(CW-ogi_pkg::XY_W){1'b0}}, req_x}) + $signed({{(CW-DW){dx[DW-1]}}, dx});
  assign ny = $signed({{(CW-ogi_pkg::XY_W){1'b0}}, req_y}) + $signed({{(CW-DW){dy[DW-1]}}, dy});

  assign dx_mag = dx[DW-1] ? RW'(-dx) : RW'(dx);
  assign dy_mag = dy[DW-1] ? RW'(-dy) : RW'(dy);
  assign d_sq   = {1'b0, {RW'(0), dx_mag} * {RW'(0), dx_mag}}
                + {1'b0, {RW'(0), dy_mag} * {RW'(0), dy_mag}};
  assign r_sq   = {RW'(0), r_eff} * {RW'(0), r_eff};

  assign nbr_ok = !nx[CW-1] && (nx[CW-2:0] < w_eff) && !ny[CW-1] && (ny[CW-2:0] < h_eff)
                && (d_sq <= {1'b0, r_sq});
  assign nbr_addr = ADDR_W'(ny[CW-2:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx[CW-2:0]);
  assign rd_addr  = cmd.rd_center ? ctr_addr : nbr_addr;

  always_ff @(posedge clk) begin
    if (cmd.write && !in_oob) begin
      mem[in_addr] <= raw_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_x   <= cell_x;
      req_y   <= cell_y;
      req_oob <= in_oob;
    end
    if (cmd.scan_init) begin
      dx <= -r_s;
      dy <= -r_s;
    end else if (cmd.scan_step) begin
      if (dx == r_s) begin
        dx <= -r_s;
        dy <= dy + DW'(1);
      end else begin
        dx <= dx + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= cmd.scan_step && nbr_ok;
    end
  end

  assign status.in_oob         = in_oob;
  assign status.center_unknown = rd_data[ogi_pkg::VAL_W-1];
  assign status.center_obst    = ogi_pkg::is_obst(rd_data, cfg.threshold);
  assign status.hit            = rd_live && ogi_pkg::is_obst(rd_data, cfg.threshold);
  assign status.last           = (dx == r_s) && (dy == r_s);
  assign status.out_busy       = out_valid && !out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_x      <= req_x;
      result_y      <= req_y;
      out_of_bounds <= req_oob;
      unique case (cmd.kind)
        ogi_pkg::RES_BLOCKED: begin
          inflated_value    <= ogi_pkg::INF_BLOCKED;
          free_for_planning <= (cfg.threshold > 7'd100);
        end
        ogi_pkg::RES_FREE: begin
          inflated_value    <= ogi_pkg::INF_FREE;
          free_for_planning <= (cfg.threshold != '0);
        end
        default: begin
          inflated_value    <= ogi_pkg::INF_UNKNOWN;
          free_for_planning <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== design/occupancy_grid_obstacle_inflation_top.sv =====
// Top level of the occupancy grid obstacle inflation block: register port and glue.
//
//   Channel   Signals                                               Direction
//   in        in_valid/in_ready, op, cell_x, cell_y, raw_value      into block
//   out       out_valid/out_ready, result_x, result_y,              out of block
//             inflated_value, free_for_planning, out_of_bounds
//   cfg       psel, penable, pwrite, paddr, pwdata, prdata, pready  register port
//
// A write word goes into the grid from the idle state. A read word scans the disk of radius r,
// r being the effective radius; it ends early when the cell is out of bounds, the centre cell
// decides it or an obstacle is found. The single grid read port gives one neighbour per cycle.
// Reset clears the control state and loads the register defaults; the grid is not cleared.
// A new word is taken while a finished result waits in the output register.
module occupancy_grid_obstacle_inflation_top #(
  parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ogi_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = ogi_pkg::DEF_MAX_RADIUS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [ogi_pkg::XY_W-1:0]            cell_x,
  input  logic [ogi_pkg::XY_W-1:0]            cell_y,
  input  logic signed [ogi_pkg::VAL_W-1:0]    raw_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ogi_pkg::XY_W-1:0]            result_x,
  output logic [ogi_pkg::XY_W-1:0]            result_y,
  output logic signed [ogi_pkg::VAL_W-1:0]    inflated_value,
  output logic                                free_for_planning,
  output logic                                out_of_bounds,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ogi_pkg::PADDR_W-1:0]         paddr,
  input  logic [ogi_pkg::PDATA_W-1:0]         pwdata,
  output logic [ogi_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  ogi_pkg::cfg_t     cfg;
  ogi_pkg::cmd_t     cmd;
  ogi_pkg::status_t  status;
  ogi_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = ogi_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= ogi_pkg::RST_THRESHOLD;
      cfg.radius    <= ogi_pkg::RST_RADIUS;
      cfg.width     <= ogi_pkg::RST_WIDTH;
      cfg.height    <= ogi_pkg::RST_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        ogi_pkg::REG_THRESHOLD: cfg.threshold <= pwdata[ogi_pkg::THR_W-1:0];
        ogi_pkg::REG_RADIUS:    cfg.radius    <= pwdata[ogi_pkg::RAD_W-1:0];
        ogi_pkg::REG_WIDTH:     cfg.width     <= pwdata[ogi_pkg::DIM_W-1:0];
        ogi_pkg::REG_HEIGHT:    cfg.height    <= pwdata[ogi_pkg::DIM_W-1:0];
        default:                cfg.height    <= cfg.height;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ogi_pkg::REG_THRESHOLD: prdata = ogi_pkg::PDATA_W'(cfg.threshold);
      ogi_pkg::REG_RADIUS:    prdata = ogi_pkg::PDATA_W'(cfg.radius);
      ogi_pkg::REG_WIDTH:     prdata = ogi_pkg::PDATA_W'(cfg.width);
      ogi_pkg::REG_HEIGHT:    prdata = ogi_pkg::PDATA_W'(cfg.height);
      default:                prdata = '0;
    endcase
  end

  ogi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ogi_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .cell_x            (cell_x),
    .cell_y            (cell_y),
    .raw_value         (raw_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .result_x          (result_x),
    .result_y          (result_y),
    .inflated_value    (inflated_value),
    .free_for_planning (free_for_planning),
    .out_of_bounds     (out_of_bounds)
  );

endmodule
